[design/i2cbm_pkg.sv]
package i2cbm_pkg;

    // Width of the per-step hold counter
    localparam int unsigned HOLD_CNT_W = 8;
    localparam int unsigned HOLD_REG_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD = 2'd1;

    // Reset values of the hold registers
    localparam logic [HOLD_REG_W-1:0] LONG_HOLD_RST  = 8'd25;
    localparam logic [HOLD_REG_W-1:0] SHORT_HOLD_RST = 8'd5;

    // Bus commands
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_ACK   = 3'd4,
        CMD_NACK  = 3'd5
    } cmd_t;

    // Hold length selected by a step
    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_SHORT = 2'd1,
        HOLD_LONG  = 2'd2
    } hold_kind_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] req_type;
        logic [7:0] write_byte;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_bit;
    } out_item_t;

    // Remaining ticks after the entry tick: max(1, ticks) - 1, saturated
    function automatic logic [HOLD_CNT_W-1:0] hold_load(input logic [HOLD_REG_W-1:0] ticks);
        logic [HOLD_REG_W-1:0] dur;
        logic [15:0]           dur16;
        logic [15:0]           lim16;
        dur   = (ticks == '0) ? '0 : ticks - 1'b1;
        dur16 = 16'(dur);
        lim16 = 16'((32'd1 << HOLD_CNT_W) - 32'd1);
        return HOLD_CNT_W'((dur16 > lim16) ? lim16 : dur16);
    endfunction

endpackage

[design/i2c_bit_level_master.sv]
// I2C master line sequencer. Each accepted input transfer is one timing tick: it may
// carry a command (start, stop, write byte, read byte, ack, nack) and always carries
// the sampled SDA level. Every tick produces exactly one result transfer with the
// driven SCL/SDA levels, busy/done flags, the last read byte and the last write's
// acknowledge bit. One tick is accepted per clock cycle; the tick's update runs in a
// single pass from the sequencer state to the output register, so s_ready only drops
// while a result is waiting and m_ready is low. Hold lengths come from the long and
// short hold registers (index 0 and 1, zero acts as one tick). Commands arriving while
// busy are ignored; there is no clock stretching or arbitration. Both lines reset high.
module i2c_bit_level_master (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  i2cbm_pkg::in_item_t                  s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output i2cbm_pkg::out_item_t                 m_payload,
    input  logic                                 cfg_wr_en,
    input  logic [i2cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [i2cbm_pkg::HOLD_REG_W-1:0] long_hold_reg;
    logic [i2cbm_pkg::HOLD_REG_W-1:0] short_hold_reg;
    logic                             out_valid_reg;
    i2cbm_pkg::out_item_t             out_data_reg;
    i2cbm_pkg::out_item_t             step_result;
    logic                             s_xfer;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_hold_reg  <= i2cbm_pkg::LONG_HOLD_RST;
            short_hold_reg <= i2cbm_pkg::SHORT_HOLD_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == i2cbm_pkg::CFG_LONG_HOLD) begin
                long_hold_reg <= cfg_wdata;
            end else if (cfg_index == i2cbm_pkg::CFG_SHORT_HOLD) begin
                short_hold_reg <= cfg_wdata;
            end
        end
    end

    // Accept whenever the output slot is free or being drained
    assign s_ready = !out_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    i2cbm_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (s_xfer),
        .item       (s_payload),
        .long_hold  (long_hold_reg),
        .short_hold (short_hold_reg),
        .result     (step_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    // A completing tick never reports busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.done_res) |-> !m_payload.busy_res)
        else $error("done while busy");

    // Every accepted tick yields a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid)
        else $error("accepted tick without result");

    // Done pulses for a single result only
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && m_valid && m_payload.done_res && !m_payload.busy_res &&
         $past(s_xfer)) |=> (!m_payload.done_res || !$past(m_payload.done_res)))
        else $error("done held across ticks");

endmodule

[design/i2cbm_seq.sv]
module i2cbm_seq (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step_en,
    input  i2cbm_pkg::in_item_t                  item,
    input  logic [i2cbm_pkg::HOLD_REG_W-1:0]     long_hold,
    input  logic [i2cbm_pkg::HOLD_REG_W-1:0]     short_hold,
    output i2cbm_pkg::out_item_t                 result
);

    logic                              idle_reg, idle_next;
    i2cbm_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [2:0]                        phase_reg, phase_next;
    logic [3:0]                        bit_cnt_reg, bit_cnt_next;
    logic [7:0]                        shift_reg, shift_next;
    logic [i2cbm_pkg::HOLD_CNT_W-1:0]  hold_reg, hold_next;
    logic                              scl_reg, scl_next;
    logic                              sda_reg, sda_next;
    logic                              ack_reg, ack_next;
    logic [7:0]                        rdata_reg, rdata_next;

    // Step sequencing for one tick
    always_comb begin
        logic                  enter;
        logic                  stepped;
        logic                  last;
        i2cbm_pkg::hold_kind_t kind;
        logic [3:0]            bit_inc;

        idle_next    = idle_reg;
        cmd_next     = cmd_reg;
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        hold_next    = hold_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        ack_next     = ack_reg;
        rdata_next   = rdata_reg;
        enter        = 1'b0;
        stepped      = 1'b0;
        kind         = i2cbm_pkg::HOLD_NONE;
        bit_inc      = bit_cnt_reg + 4'd1;

        // Launch a new command or advance the running one
        if (idle_reg) begin
            if (item.cmd_valid && (item.req_type <= 3'(i2cbm_pkg::CMD_NACK))) begin
                cmd_next     = i2cbm_pkg::cmd_t'(item.req_type);
                phase_next   = 3'd0;
                bit_cnt_next = 4'd0;
                shift_next   = (item.req_type == 3'(i2cbm_pkg::CMD_WRITE)) ?
                               item.write_byte : 8'h00;
                idle_next    = 1'b0;
                enter        = 1'b1;
                stepped      = 1'b1;
            end
        end else begin
            stepped = 1'b1;
            if (hold_reg != '0) begin
                hold_next = hold_reg - 1'b1;
            end else begin
                enter = 1'b1;
                if (cmd_reg == i2cbm_pkg::CMD_WRITE && phase_reg == 3'd2) begin
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_inc;
                    phase_next   = bit_inc[3] ? 3'd3 : 3'd0;
                end else if (cmd_reg == i2cbm_pkg::CMD_READ && phase_reg == 3'd1) begin
                    bit_cnt_next = bit_inc;
                    phase_next   = 3'd0;
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
        end

        // Line write of the entered step
        if (enter) begin
            unique case (cmd_next)
                i2cbm_pkg::CMD_START: begin
                    unique case (phase_next)
                        3'd0:    scl_next = 1'b1;
                        3'd1:    begin sda_next = 1'b1; kind = i2cbm_pkg::HOLD_LONG;  end
                        3'd2:    begin sda_next = 1'b0; kind = i2cbm_pkg::HOLD_SHORT; end
                        default: begin scl_next = 1'b0; kind = i2cbm_pkg::HOLD_SHORT; end
                    endcase
                end
                i2cbm_pkg::CMD_STOP: begin
                    unique case (phase_next)
                        3'd0:    begin sda_next = 1'b0; kind = i2cbm_pkg::HOLD_SHORT; end
                        3'd1:    begin scl_next = 1'b1; kind = i2cbm_pkg::HOLD_LONG;  end
                        default: sda_next = 1'b1;
                    endcase
                end
                i2cbm_pkg::CMD_WRITE: begin
                    unique case (phase_next)
                        3'd0: begin
                            sda_next = shift_next[7];
                            kind     = shift_next[7] ? i2cbm_pkg::HOLD_SHORT :
                                                       i2cbm_pkg::HOLD_NONE;
                        end
                        3'd1:    begin scl_next = 1'b1; kind = i2cbm_pkg::HOLD_LONG; end
                        3'd2:    scl_next = 1'b0;
                        3'd3:    begin sda_next = 1'b1; kind = i2cbm_pkg::HOLD_LONG; end
                        3'd4: begin
                            scl_next = 1'b1;
                            ack_next = item.sda_sample;
                            kind     = i2cbm_pkg::HOLD_LONG;
                        end
                        default: begin scl_next = 1'b0; kind = i2cbm_pkg::HOLD_SHORT; end
                    endcase
                end
                i2cbm_pkg::CMD_READ: begin
                    // Data bit is taken as SCL falls
                    if (phase_next == 3'd0) begin
                        scl_next = 1'b1;
                    end else begin
                        shift_next = {shift_next[6:0], item.sda_sample};
                        scl_next   = 1'b0;
                    end
                    kind = i2cbm_pkg::HOLD_LONG;
                end
                i2cbm_pkg::CMD_ACK: begin
                    unique case (phase_next)
                        3'd0:    begin sda_next = 1'b0; kind = i2cbm_pkg::HOLD_LONG; end
                        3'd1:    begin scl_next = 1'b1; kind = i2cbm_pkg::HOLD_LONG; end
                        3'd2:    scl_next = 1'b0;
                        default: begin sda_next = 1'b1; kind = i2cbm_pkg::HOLD_LONG; end
                    endcase
                end
                default: begin
                    unique case (phase_next)
                        3'd0:    sda_next = 1'b1;
                        3'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                    kind = i2cbm_pkg::HOLD_LONG;
                end
            endcase

            unique case (kind)
                i2cbm_pkg::HOLD_SHORT: hold_next = i2cbm_pkg::hold_load(short_hold);
                i2cbm_pkg::HOLD_LONG:  hold_next = i2cbm_pkg::hold_load(long_hold);
                default:               hold_next = '0;
            endcase
        end

        // Completion on the last tick of the last step
        unique case (cmd_next)
            i2cbm_pkg::CMD_START: last = (phase_next >= 3'd3);
            i2cbm_pkg::CMD_STOP:  last = (phase_next >= 3'd2);
            i2cbm_pkg::CMD_WRITE: last = (phase_next >= 3'd5);
            i2cbm_pkg::CMD_READ:  last = (phase_next >= 3'd1) && (bit_cnt_next >= 4'd7);
            i2cbm_pkg::CMD_ACK:   last = (phase_next >= 3'd3);
            default:              last = (phase_next >= 3'd2);
        endcase

        result.done_res = 1'b0;
        if (stepped && hold_next == '0 && last) begin
            if (cmd_next == i2cbm_pkg::CMD_READ) begin
                rdata_next = shift_next;
            end
            idle_next       = 1'b1;
            result.done_res = 1'b1;
        end

        result.scl_level = scl_next;
        result.sda_level = sda_next;
        result.busy_res  = !idle_next;
        result.read_byte = rdata_next;
        result.ack_bit   = ack_next;
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg    <= 1'b1;
            cmd_reg     <= i2cbm_pkg::CMD_START;
            phase_reg   <= 3'd0;
            bit_cnt_reg <= 4'd0;
            shift_reg   <= 8'h00;
            hold_reg    <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            ack_reg     <= 1'b0;
            rdata_reg   <= 8'h00;
        end else if (step_en) begin
            idle_reg    <= idle_next;
            cmd_reg     <= cmd_next;
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            hold_reg    <= hold_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            ack_reg     <= ack_next;
            rdata_reg   <= rdata_next;
        end
    end

    // An idle sequencer never carries a pending hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        idle_reg |-> (hold_reg == '0))
        else $error("hold pending while idle");

    // Read never counts past its eighth bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!idle_reg && cmd_reg == i2cbm_pkg::CMD_READ) |-> (bit_cnt_reg <= 4'd7))
        else $error("read bit count overrun");

    // Write bit count stops at eight, and only the tail steps run there
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!idle_reg && cmd_reg == i2cbm_pkg::CMD_WRITE && bit_cnt_reg[3]) |->
        (phase_reg >= 3'd3 && bit_cnt_reg == 4'd8))
        else $error("write bit count out of step");

endmodule

[dv/i2c_bit_level_master_tb.sv]
`timescale 1ns / 1ps

module i2c_bit_level_master_tb;

    localparam logic [3:0]  SEQ_IDLE      = 4'd15;
    localparam int unsigned HOLD_MAX      = (1 << i2cbm_pkg::HOLD_CNT_W) - 1;
    localparam int unsigned TICK_BUDGET   = 60;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 80000;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned LONG_STALL    = 60;

    // Request codes the sequencer does not define
    localparam logic [2:0] REQ_RSVD_6 = 3'd6;
    localparam logic [2:0] REQ_RSVD_7 = 3'd7;

    // Register indexes with no register behind them
    localparam logic [i2cbm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [i2cbm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

    // How filler ticks pick the sampled SDA level
    typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_t;

    typedef logic [i2cbm_pkg::HOLD_CNT_W-1:0] hold_cnt_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    i2cbm_pkg::in_item_t              s_payload;
    logic                             m_valid;
    logic                             m_ready;
    i2cbm_pkg::out_item_t             m_payload;
    logic                             cfg_wr_en;
    logic [i2cbm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [i2cbm_pkg::CFG_DATA_W-1:0] cfg_wdata;

    i2c_bit_level_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Line sequencer model state
    logic [3:0]            seq_phase;
    i2cbm_pkg::cmd_t       seq_cmd;
    logic [3:0]            bits_done;
    logic [7:0]            shifter;
    hold_cnt_t             hold_left;
    logic                  scl_q;
    logic                  sda_q;
    logic                  ack_q;
    logic [7:0]            last_rd;
    logic [7:0]            long_ticks;
    logic [7:0]            short_ticks;

    i2cbm_pkg::out_item_t expected_lines[$];
    int unsigned mismatches  = 0;
    int unsigned lines_seen  = 0;
    int unsigned tick_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_hold   = 0;
    bit          src_gaps    = 1'b0;
    bit          sink_stalls = 1'b0;
    sda_mode_t   sda_mode    = SDA_RANDOM;

    // Clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("i2c_bit_level_master verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------

    function automatic void model_reset();
        long_ticks  = i2cbm_pkg::LONG_HOLD_RST;
        short_ticks = i2cbm_pkg::SHORT_HOLD_RST;
        seq_phase   = SEQ_IDLE;
        seq_cmd     = i2cbm_pkg::CMD_START;
        bits_done   = '0;
        shifter     = '0;
        hold_left   = '0;
        scl_q       = 1'b1;
        sda_q       = 1'b1;
        ack_q       = 1'b0;
        last_rd     = '0;
    endfunction

    // Ticks left after the entry tick; zero behaves as one tick
    function automatic void load_hold(i2cbm_pkg::hold_kind_t kind);
        int unsigned ticks;
        ticks = 1;
        if (kind == i2cbm_pkg::HOLD_SHORT)
            ticks = 32'(short_ticks);
        else if (kind == i2cbm_pkg::HOLD_LONG)
            ticks = 32'(long_ticks);
        if (ticks == 0)
            ticks = 1;
        ticks = ticks - 1;
        hold_left = hold_cnt_t'((ticks > HOLD_MAX) ? HOLD_MAX : ticks);
    endfunction

    // Line write made on entry to the current step
    function automatic void drive_step(logic sda_in);
        i2cbm_pkg::hold_kind_t kind;
        kind = i2cbm_pkg::HOLD_NONE;
        case (seq_cmd)
            i2cbm_pkg::CMD_START: begin
                if (seq_phase == 4'd0) begin
                    scl_q = 1'b1;
                end else if (seq_phase == 4'd1) begin
                    sda_q = 1'b1;
                    kind  = i2cbm_pkg::HOLD_LONG;
                end else if (seq_phase == 4'd2) begin
                    sda_q = 1'b0;
                    kind  = i2cbm_pkg::HOLD_SHORT;
                end else begin
                    scl_q = 1'b0;
                    kind  = i2cbm_pkg::HOLD_SHORT;
                end
            end
            i2cbm_pkg::CMD_STOP: begin
                if (seq_phase == 4'd0) begin
                    sda_q = 1'b0;
                    kind  = i2cbm_pkg::HOLD_SHORT;
                end else if (seq_phase == 4'd1) begin
                    scl_q = 1'b1;
                    kind  = i2cbm_pkg::HOLD_LONG;
                end else begin
                    sda_q = 1'b1;
                end
            end
            i2cbm_pkg::CMD_WRITE: begin
                if (seq_phase == 4'd0) begin
                    sda_q = shifter[7];
                    kind  = sda_q ? i2cbm_pkg::HOLD_SHORT : i2cbm_pkg::HOLD_NONE;
                end else if (seq_phase == 4'd1) begin
                    scl_q = 1'b1;
                    kind  = i2cbm_pkg::HOLD_LONG;
                end else if (seq_phase == 4'd2) begin
                    scl_q = 1'b0;
                end else if (seq_phase == 4'd3) begin
                    sda_q = 1'b1;
                    kind  = i2cbm_pkg::HOLD_LONG;
                end else if (seq_phase == 4'd4) begin
                    // acknowledge sampled as SCL rises
                    scl_q = 1'b1;
                    ack_q = sda_in;
                    kind  = i2cbm_pkg::HOLD_LONG;
                end else begin
                    scl_q = 1'b0;
                    kind  = i2cbm_pkg::HOLD_SHORT;
                end
            end
            i2cbm_pkg::CMD_READ: begin
                if (seq_phase == 4'd0) begin
                    scl_q = 1'b1;
                end else begin
                    shifter = {shifter[6:0], sda_in};
                    scl_q   = 1'b0;
                end
                kind = i2cbm_pkg::HOLD_LONG;
            end
            i2cbm_pkg::CMD_ACK: begin
                if (seq_phase == 4'd0) begin
                    sda_q = 1'b0;
                    kind  = i2cbm_pkg::HOLD_LONG;
                end else if (seq_phase == 4'd1) begin
                    scl_q = 1'b1;
                    kind  = i2cbm_pkg::HOLD_LONG;
                end else if (seq_phase == 4'd2) begin
                    scl_q = 1'b0;
                end else begin
                    sda_q = 1'b1;
                    kind  = i2cbm_pkg::HOLD_LONG;
                end
            end
            default: begin
                // nack
                if (seq_phase == 4'd0)
                    sda_q = 1'b1;
                else if (seq_phase == 4'd1)
                    scl_q = 1'b1;
                else
                    scl_q = 1'b0;
                kind = i2cbm_pkg::HOLD_LONG;
            end
        endcase
        load_hold(kind);
    endfunction

    function automatic bit on_last_step();
        case (seq_cmd)
            i2cbm_pkg::CMD_START: return seq_phase >= 4'd3;
            i2cbm_pkg::CMD_STOP:  return seq_phase >= 4'd2;
            i2cbm_pkg::CMD_WRITE: return seq_phase >= 4'd5;
            i2cbm_pkg::CMD_READ:  return seq_phase >= 4'd1 && bits_done >= 4'd7;
            i2cbm_pkg::CMD_ACK:   return seq_phase >= 4'd3;
            default:              return seq_phase >= 4'd2;
        endcase
    endfunction

    function automatic void next_step();
        if (seq_cmd == i2cbm_pkg::CMD_WRITE && seq_phase == 4'd2) begin
            shifter   = {shifter[6:0], 1'b0};
            bits_done = bits_done + 4'd1;
            seq_phase = (bits_done < 4'd8) ? 4'd0 : 4'd3;
        end else if (seq_cmd == i2cbm_pkg::CMD_READ && seq_phase == 4'd1) begin
            bits_done = bits_done + 4'd1;
            seq_phase = 4'd0;
        end else begin
            seq_phase = seq_phase + 4'd1;
        end
    endfunction

    // One tick of the sequencer; returns the line levels and flags it drives
    function automatic i2cbm_pkg::out_item_t step_sequencer(i2cbm_pkg::in_item_t tick);
        i2cbm_pkg::out_item_t line;
        bit                   stepped;
        bit                   done;
        stepped = 1'b0;
        done    = 1'b0;
        if (seq_phase == SEQ_IDLE) begin
            if (tick.cmd_valid && tick.req_type <= i2cbm_pkg::CMD_NACK) begin
                seq_cmd   = i2cbm_pkg::cmd_t'(tick.req_type);
                seq_phase = 4'd0;
                bits_done = '0;
                shifter   = (tick.req_type == i2cbm_pkg::CMD_WRITE) ?
                            tick.write_byte : 8'h00;
                drive_step(tick.sda_sample);
                stepped = 1'b1;
            end
        end else begin
            if (hold_left != 0) begin
                hold_left = hold_left - 1'b1;
            end else begin
                next_step();
                drive_step(tick.sda_sample);
            end
            stepped = 1'b1;
        end
        if (stepped && hold_left == 0 && on_last_step()) begin
            if (seq_cmd == i2cbm_pkg::CMD_READ)
                last_rd = shifter;
            seq_phase = SEQ_IDLE;
            done      = 1'b1;
        end
        line.scl_level = scl_q;
        line.sda_level = sda_q;
        line.busy_res  = (seq_phase != SEQ_IDLE);
        line.done_res  = done;
        line.read_byte = last_rd;
        line.ack_bit   = ack_q;
        return line;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s expected %h got %h",
                                    lines_seen, name, want, got));
    endfunction

    always @(posedge aclk) begin : result_check
        i2cbm_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_lines.size() == 0) begin
                note_mismatch($sformatf("result %0d with nothing expected: %p",
                                        lines_seen, m_payload));
            end else begin
                want = expected_lines.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(m_payload.scl_level));
                check_field("sda_level", 8'(want.sda_level), 8'(m_payload.sda_level));
                check_field("busy_res",  8'(want.busy_res),  8'(m_payload.busy_res));
                check_field("done_res",  8'(want.done_res),  8'(m_payload.done_res));
                check_field("read_byte", want.read_byte,     m_payload.read_byte);
                check_field("ack_bit",   8'(want.ack_bit),   8'(m_payload.ack_bit));
            end
            lines_seen++;
        end
    end

    // Result side: random stall per transfer, or one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = sink_stalls ? $urandom_range(0, 7) : 0;
            if (sink_hold != 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Tick transfer; valid stays up after acceptance when the next one follows
    task automatic send_tick(input i2cbm_pkg::in_item_t tick);
        int unsigned gap;
        gap = src_gaps ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= tick;
        do @(posedge aclk); while (!s_ready);
        expected_lines.push_back(step_sequencer(tick));
        tick_count++;
    endtask

    // Tick with random content; commands on it land while busy or idle
    function automatic i2cbm_pkg::in_item_t noise_tick();
        i2cbm_pkg::in_item_t tick;
        tick.cmd_valid  = ($urandom_range(0, 3) == 0);
        tick.req_type   = 3'($urandom_range(0, 7));
        tick.write_byte = 8'($urandom);
        if (sda_mode == SDA_RANDOM)
            tick.sda_sample = 1'($urandom);
        else
            tick.sda_sample = (sda_mode == SDA_HIGH);
        return tick;
    endfunction

    // Issue one request from idle and keep ticking until the sequencer is idle
    task automatic run_cmd(input logic [2:0] req, input logic [7:0] data);
        i2cbm_pkg::in_item_t tick;
        tick            = noise_tick();
        tick.cmd_valid  = 1'b1;
        tick.req_type   = req;
        tick.write_byte = data;
        send_tick(tick);
        while (seq_phase != SEQ_IDLE)
            send_tick(noise_tick());
    endtask

    task automatic send_quiet_ticks(input int unsigned n);
        i2cbm_pkg::in_item_t tick;
        repeat (n) begin
            tick           = noise_tick();
            tick.cmd_valid = 1'b0;
            send_tick(tick);
        end
    endtask

    // Wait out every pending result plus the output register latency
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [i2cbm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [i2cbm_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == i2cbm_pkg::CFG_LONG_HOLD)
            long_ticks = val;
        else if (idx == i2cbm_pkg::CFG_SHORT_HOLD)
            short_ticks = val;
    endtask

    task automatic set_holds(input logic [7:0] long_val, input logic [7:0] short_val);
        settle();
        write_reg(i2cbm_pkg::CFG_LONG_HOLD, long_val);
        write_reg(i2cbm_pkg::CFG_SHORT_HOLD, short_val);
    endtask

    // Start, address, a few data bytes, usually a stop; now and then stray traffic
    task automatic run_transaction();
        int unsigned n;
        if ($urandom_range(0, 4) == 0) begin
            run_cmd(3'($urandom_range(0, 7)), 8'($urandom));
            return;
        end
        run_cmd(i2cbm_pkg::CMD_START, 8'($urandom));
        run_cmd(i2cbm_pkg::CMD_WRITE, 8'($urandom));
        n = $urandom_range(1, 3);
        repeat (n) begin
            if ($urandom_range(0, 1) == 0) begin
                run_cmd(i2cbm_pkg::CMD_WRITE, 8'($urandom));
            end else begin
                run_cmd(i2cbm_pkg::CMD_READ, 8'($urandom));
                run_cmd(($urandom_range(0, 1) == 0) ? i2cbm_pkg::CMD_ACK :
                        i2cbm_pkg::CMD_NACK, 8'($urandom));
            end
        end
        // occasionally leave the bus open for a repeated start
        if ($urandom_range(0, 5) != 0)
            run_cmd(i2cbm_pkg::CMD_STOP, 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset hold lengths, idle ticks and undefined request codes
    task automatic test_reset_values();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_quiet_ticks(3);
        run_cmd(REQ_RSVD_6, 8'hFF);
        run_cmd(REQ_RSVD_7, 8'h00);
        run_cmd(i2cbm_pkg::CMD_START, 8'h00);
        run_cmd(i2cbm_pkg::CMD_STOP, 8'hFF);
    endtask

    // Every command, byte extremes, both acknowledge levels
    task automatic test_each_command();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        set_holds(8'd1, 8'd2);
        run_cmd(i2cbm_pkg::CMD_START, 8'h00);
        run_cmd(i2cbm_pkg::CMD_WRITE, 8'h00);
        sda_mode = SDA_HIGH;
        run_cmd(i2cbm_pkg::CMD_WRITE, 8'hFF);
        run_cmd(i2cbm_pkg::CMD_READ, 8'h00);
        sda_mode = SDA_LOW;
        run_cmd(i2cbm_pkg::CMD_WRITE, 8'hA5);
        run_cmd(i2cbm_pkg::CMD_READ, 8'hFF);
        sda_mode = SDA_RANDOM;
        run_cmd(i2cbm_pkg::CMD_READ, 8'h3C);
        run_cmd(i2cbm_pkg::CMD_ACK, 8'h00);
        run_cmd(i2cbm_pkg::CMD_NACK, 8'h00);
        run_cmd(i2cbm_pkg::CMD_STOP, 8'h00);
    endtask

    // Hold registers at zero act as one tick
    task automatic test_zero_holds();
        set_holds(8'd0, 8'd0);
        run_cmd(i2cbm_pkg::CMD_START, 8'h00);
        run_cmd(i2cbm_pkg::CMD_WRITE, 8'($urandom));
        run_cmd(i2cbm_pkg::CMD_READ, 8'h00);
        run_cmd(i2cbm_pkg::CMD_ACK, 8'h00);
        run_cmd(i2cbm_pkg::CMD_NACK, 8'h00);
        run_cmd(i2cbm_pkg::CMD_STOP, 8'h00);
    endtask

    // Long holds in both hold registers; no idling so the run stays short
    task automatic test_long_holds();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        set_holds(8'd60, 8'd40);
        run_cmd(i2cbm_pkg::CMD_STOP, 8'h00);
    endtask

    // Writes to indexes past the last register change nothing
    task automatic test_unused_index();
        set_holds(8'd4, 8'd1);
        write_reg(CFG_UNUSED_2, 8'hFF);
        write_reg(CFG_UNUSED_3, 8'h00);
        run_cmd(i2cbm_pkg::CMD_START, 8'h00);
        run_cmd(i2cbm_pkg::CMD_STOP, 8'h00);
    endtask

    // Result side holds off while ticks keep coming; input must stall
    task automatic test_backpressure();
        set_holds(8'd2, 8'd1);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        sink_hold   = LONG_STALL;
        run_cmd(i2cbm_pkg::CMD_START, 8'h00);
        run_cmd(i2cbm_pkg::CMD_WRITE, 8'($urandom));
        run_cmd(i2cbm_pkg::CMD_NACK, 8'h00);
        run_cmd(i2cbm_pkg::CMD_STOP, 8'h00);
    endtask

    // Random transactions over a range of hold settings
    task automatic test_random();
        int unsigned stop_at;
        logic [7:0]  long_val;
        logic [7:0]  short_val;
        stop_at = tick_count + TICK_BUDGET;
        while (tick_count < stop_at) begin
            long_val  = 8'($urandom_range(0, 4));
            short_val = 8'($urandom_range(0, 3));
            set_holds(long_val, short_val);
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            run_transaction();
        end
    endtask

    initial begin
        s_valid   = 1'b0;
        s_payload = '0;
        cfg_wr_en = 1'b0;
        cfg_index = i2cbm_pkg::CFG_LONG_HOLD;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        model_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_each_command();
        test_zero_holds();
        test_long_holds();
        test_unused_index();
        test_backpressure();
        test_random();

        settle();
        repeat (8) @(posedge aclk);
        if (expected_lines.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_lines.size()));
        if (mismatches == 0) begin
            $display("i2c_bit_level_master verification clean");
        end else begin
            $display("i2c_bit_level_master verification failed");
        end
        $finish;
    end

endmodule
